FILE: rtl/lsb_stego_embed_extract_assert.svh
// assertion macros for the lsb stego embed/extract checker
// expects signals clk and rst_n in the scope of each use
`ifndef LSB_STEGO_EMBED_EXTRACT_ASSERT_SVH
`define LSB_STEGO_EMBED_EXTRACT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LSE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lse check failed");

// next-cycle implication, disabled while in reset
`define LSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lse check failed");

`endif

FILE: rtl/lse_pkg.sv
// shared types and constants for the lsb stego embed/extract block
// no dependencies
package lse_pkg;

  localparam int HEADER_BITS_DEF      = 32;
  localparam int PIXEL_INDEX_BITS_DEF = 24;

  localparam int PIX_W     = 8;
  localparam int LEN_W     = 22;
  localparam int IMG_W     = 25;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [PIX_W-1:0] LSB_CLEAR_MASK = 8'hFE;
  localparam logic [2:0]       BYTE_LAST_BIT  = 3'd7;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(2097152);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE           = 2'd0,
    REG_PAYLOAD_LENGTH = 2'd1,
    REG_IMAGE_SIZE     = 2'd2,
    REG_MAX_PAYLOAD    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_EMBED   = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_OVER_CAP   = 3'd2,
    ST_IMG_SMALL  = 3'd3,
    ST_NO_DATA    = 3'd4,
    ST_OVER_MAX   = 3'd5,
    ST_OVER_IMAGE = 3'd6
  } status_t;

  typedef struct packed {
    mode_t             mode;
    logic [LEN_W-1:0]  payload_length;
    logic [IMG_W-1:0]  image_size;
    logic [LEN_W-1:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    status_t          status;
    logic             byte_valid;
    logic [PIX_W-1:0] data_byte;
    logic             last_byte;
  } result_t;

endpackage

FILE: rtl/lse_cfg.sv
// configuration registers of the lsb stego block
// depends on lse_pkg
module lse_cfg import lse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:           cfg_nxt.mode           = mode_t'(cfg_data[0]);
        REG_PAYLOAD_LENGTH: cfg_nxt.payload_length = cfg_data[LEN_W-1:0];
        REG_IMAGE_SIZE:     cfg_nxt.image_size     = cfg_data[IMG_W-1:0];
        REG_MAX_PAYLOAD:    cfg_nxt.max_payload    = cfg_data[LEN_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= MODE_EMBED;
      cfg_r.payload_length <= '0;
      cfg_r.image_size     <= '0;
      cfg_r.max_payload    <= MAX_PAYLOAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/lse_step.sv
// per-pixel embed/extract logic: next frame state and result word
// depends on lse_pkg
module lse_step import lse_pkg::*; #(
  parameter int HEADER_BITS      = HEADER_BITS_DEF,
  parameter int PIXEL_INDEX_BITS = PIXEL_INDEX_BITS_DEF
) (
  input  cfg_t                    cfg,
  input  logic [PIX_W-1:0]        pix,
  input  logic                    start,
  input  logic [PIX_W-1:0]        pbyte,
  input  logic [PIXEL_INDEX_BITS:0] idx_r,
  input  logic [HEADER_BITS-1:0]  hdr_r,
  input  logic [PIX_W-1:0]        asm_r,
  input  logic [PIX_W-1:0]        latch_r,
  input  status_t                 err_r,
  output logic [PIXEL_INDEX_BITS:0] idx_nxt,
  output logic [HEADER_BITS-1:0]  hdr_nxt,
  output logic [PIX_W-1:0]        asm_nxt,
  output logic [PIX_W-1:0]        latch_nxt,
  output status_t                 err_nxt,
  output result_t                 res
);

  localparam int IW  = PIXEL_INDEX_BITS + 1;
  localparam int HIW = $clog2(HEADER_BITS);
  localparam int W1  = (IW > HEADER_BITS + 3) ? IW : HEADER_BITS + 3;
  localparam int W2  = (W1 > LEN_W + 3) ? W1 : LEN_W + 3;
  localparam int CW  = ((W2 > IMG_W) ? W2 : IMG_W) + 1;
  localparam logic [CW-1:0] HB_C      = CW'(HEADER_BITS);
  localparam logic [CW-1:0] HB_LAST_C = CW'(HEADER_BITS - 1);

  logic [IW-1:0]          idx;
  logic [HEADER_BITS-1:0] hdr0;
  logic [PIX_W-1:0]       asm0;
  status_t                err0;
  logic [CW-1:0]          idx_c;
  logic                   is_first, in_header, is_hdr_last, in_data, img_small;
  logic [HIW-1:0]         hsel;
  logic [HEADER_BITS-1:0] len_e, hdr_x, data_len;
  logic [CW-1:0]          chk_len;
  logic                   chk_zero, chk_max, chk_fit;
  logic [IW-1:0]          k;
  logic [2:0]             bp;
  logic [CW-1:0]          byte_no;
  logic [PIX_W-1:0]       asm_set;
  logic                   is_extract;

  // frame start restarts counters, header, assembler and status
  assign idx  = start ? '0 : idx_r;
  assign hdr0 = start ? '0 : hdr_r;
  assign asm0 = start ? '0 : asm_r;
  assign err0 = start ? ST_OK : err_r;

  assign is_extract  = (cfg.mode == MODE_EXTRACT);
  assign idx_c       = CW'(idx);
  assign is_first    = (idx == '0);
  assign in_header   = (idx_c < HB_C);
  assign is_hdr_last = (idx_c == HB_LAST_C);
  assign img_small   = (cfg.image_size < IMG_W'(HEADER_BITS));
  assign hsel        = idx[HIW-1:0];

  assign len_e = is_first ? HEADER_BITS'(cfg.payload_length) : hdr0;
  assign hdr_x = hdr0 | (HEADER_BITS'(pix[0]) << hsel);

  // one set of length checks shared by both modes
  assign chk_len  = is_extract ? CW'(hdr_x) : CW'(cfg.payload_length);
  assign chk_zero = (chk_len == '0);
  assign chk_max  = (chk_len > CW'(cfg.max_payload));
  assign chk_fit  = ((HB_C + (chk_len << 3)) > CW'(cfg.image_size));

  assign data_len = is_extract ? hdr0 : len_e;
  assign in_data  = (idx_c < (HB_C + (CW'(data_len) << 3)));
  assign k        = idx - IW'(HEADER_BITS);
  assign bp       = k[2:0];
  assign byte_no  = CW'(k[IW-1:3]);
  assign asm_set  = asm0 | (PIX_W'(pix[0]) << bp);

  always_comb begin
    idx_nxt   = (&idx) ? idx : idx + IW'(1);
    hdr_nxt   = hdr0;
    asm_nxt   = asm0;
    latch_nxt = latch_r;
    err_nxt   = err0;
    res.pixel_out  = pix;
    res.byte_valid = 1'b0;
    res.data_byte  = '0;
    res.last_byte  = 1'b0;
    if (!is_extract) begin
      if (is_first) begin
        hdr_nxt = len_e;
        if (chk_zero)       err_nxt = ST_EMPTY;
        else if (img_small) err_nxt = ST_IMG_SMALL;
        else if (chk_max)   err_nxt = ST_OVER_MAX;
        else if (chk_fit)   err_nxt = ST_OVER_CAP;
        else                err_nxt = ST_OK;
      end
      if (err_nxt == ST_OK) begin
        if (in_header) begin
          res.pixel_out = (pix & LSB_CLEAR_MASK) | PIX_W'(len_e[hsel]);
        end else if (in_data) begin
          if (bp == 3'd0) latch_nxt = pbyte;
          res.pixel_out = (pix & LSB_CLEAR_MASK) | PIX_W'(latch_nxt[bp]);
        end
      end
    end else begin
      if (is_first && img_small) err_nxt = ST_IMG_SMALL;
      if (err_nxt == ST_OK) begin
        if (in_header) begin
          hdr_nxt = hdr_x;
          if (is_hdr_last) begin
            if (chk_zero)     err_nxt = ST_NO_DATA;
            else if (chk_max) err_nxt = ST_OVER_MAX;
            else if (chk_fit) err_nxt = ST_OVER_IMAGE;
          end
        end else if (in_data) begin
          asm_nxt = asm_set;
          if (bp == BYTE_LAST_BIT) begin
            res.byte_valid = 1'b1;
            res.data_byte  = asm_set;
            res.last_byte  = (byte_no == (CW'(hdr0) - CW'(1)));
            asm_nxt        = '0;
          end
        end
      end
    end
    res.status = err_nxt;
  end

endmodule

FILE: rtl/lsb_stego_embed_extract.sv
// top level of the lsb stego embed/extract block: input stage, frame state, result stage
// depends on lse_pkg, lse_cfg, lse_step
//
//  channel  dir  handshake         payload
//  in_      in   tvalid/tready     tdata {payload_byte, pixel_in}, tuser frame_start
//  out_     out  tvalid/tready     tdata {data_byte, status, pixel_out}, tuser byte_valid,
//                                  tlast last_byte
//  cfg_     in   we, no ready      index selects register, data up to 25 bits
//
// one word per cycle sustained while out_ is not stalled; each word passes through the
// input stage register and its result then sits in the output register
// the rate is set by the update of the frame state (pixel counter, header,
// byte assembler), which advances as a word moves from the input stage to the output
// reset is synchronous, active low, and resets config, frame state and both valid flags
// a stall on out_ holds the output word; the input stage still takes one more word
module lsb_stego_embed_extract import lse_pkg::*; #(
  parameter int HEADER_BITS      = HEADER_BITS_DEF,
  parameter int PIXEL_INDEX_BITS = PIXEL_INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] pixel_in, [15:8] payload_byte
  input  logic                   in_tuser,   // [0] frame_start
  // result words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] pixel_out, [10:8] status,
                                             // [18:11] data_byte, [23:19] zero
  output logic                   out_tuser,  // [0] byte_valid
  output logic                   out_tlast,  // last_byte
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int IW = PIXEL_INDEX_BITS + 1;

  cfg_t cfg;

  // input stage
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r, s1_pbyte_r;
  logic             s1_start_r;

  // frame state
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [HEADER_BITS-1:0] hdr_r, hdr_nxt;
  logic [PIX_W-1:0]       asm_r, asm_nxt;
  logic [PIX_W-1:0]       latch_r, latch_nxt;
  status_t                err_r, err_nxt;

  // result stage
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  logic in_fire, out_free, s1_adv;

  lse_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lse_step #(
    .HEADER_BITS      (HEADER_BITS),
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
  ) u_step (
    .cfg       (cfg),
    .pix       (s1_pix_r),
    .start     (s1_start_r),
    .pbyte     (s1_pbyte_r),
    .idx_r     (idx_r),
    .hdr_r     (hdr_r),
    .asm_r     (asm_r),
    .latch_r   (latch_r),
    .err_r     (err_r),
    .idx_nxt   (idx_nxt),
    .hdr_nxt   (hdr_nxt),
    .asm_nxt   (asm_nxt),
    .latch_nxt (latch_nxt),
    .err_nxt   (err_nxt),
    .res       (res_nxt)
  );

  // output register frees when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)     s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_adv)          out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      hdr_r       <= '0;
      asm_r       <= '0;
      latch_r     <= '0;
      err_r       <= ST_OK;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // frame state steps once per word, as it leaves the input stage
      if (s1_adv) begin
        idx_r   <= idx_nxt;
        hdr_r   <= hdr_nxt;
        asm_r   <= asm_nxt;
        latch_r <= latch_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= in_tdata[PIX_W-1:0];
      s1_pbyte_r <= in_tdata[2*PIX_W-1:PIX_W];
      s1_start_r <= in_tuser;
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.data_byte, res_r.status, res_r.pixel_out};
  assign out_tuser  = res_r.byte_valid;
  assign out_tlast  = res_r.last_byte;

endmodule

FILE: rtl/lse_checker.sv
// port-level checker for the lsb stego embed/extract block, bound to the top level
// depends on lse_pkg and lsb_stego_embed_extract_assert.svh
`include "lsb_stego_embed_extract_assert.svh"

module lse_checker import lse_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // a last byte is always a completed byte
  `LSE_ASSERT_IMPLY(a_last_is_byte, out_tvalid && out_tlast, out_tuser)
  // no completed byte means the byte field reads zero
  `LSE_ASSERT_IMPLY(a_idle_byte_zero, out_tvalid && !out_tuser, out_tdata[18:11] == 8'h00)
  // bytes are only emitted while the frame is error free
  `LSE_ASSERT_IMPLY(a_byte_ok_status, out_tvalid && out_tuser, out_tdata[10:8] == ST_OK)
  // a free output side never blocks the input side
  `LSE_ASSERT_IMPLY(a_ready_follows, out_tready, in_tready)
  // a stalled result word holds
  `LSE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind lsb_stego_embed_extract lse_checker u_lse_checker (.*);
